// ===== design/rti_pkg.sv =====
// Package for the ray/triangle intersection core.
// Holds widths, register indexes and result codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;

    // Coordinate format
    localparam int CW   = 32;           // coordinate width, signed
    localparam int FRAC = 16;           // fraction bits
    localparam int REG_W = 32;          // configuration register width
    localparam int FIELD_W = 32;        // width of a coordinate field on the buses

    // Internal exact widths
    localparam int EW   = CW + 1;       // edge and offset vectors
    localparam int PW   = 2 * EW;       // one cross-product term
    localparam int XW   = PW + 1;       // cross product component
    localparam int HW   = XW - EW;      // upper slice of a cross component
    localparam int DW   = XW + EW + 2;  // dot products
    localparam int QW   = CW - 1;       // distance bits
    localparam int RW   = DW + FRAC;    // divider remainder
    localparam int CMPW = RW + QW;      // divider compare width
    localparam int MW   = QW + CW;      // distance times direction magnitude
    localparam int SW   = MW + 2;       // point sum before saturation

    // Pipeline: edges, products, cross, dot products, terms, sums, sign,
    // tests, divider bits, point products, output
    localparam int NST  = 10 + QW;

    // Buses
    localparam int IN_TDATA_W  = ((9 * FIELD_W) + 7) / 8 * 8;
    localparam int OUT_BITS    = QW + 3 * FIELD_W;
    localparam int OUT_TDATA_W = (OUT_BITS + 7) / 8 * 8;
    localparam int USER_W      = 4;
    localparam int CFG_IDX_W   = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd6;

    // Result codes
    typedef enum logic [2:0] {
        MISS_NONE     = 3'd0,
        MISS_PARALLEL = 3'd1,
        MISS_U        = 3'd2,
        MISS_V        = 3'd3,
        MISS_BEHIND   = 3'd4
    } miss_t;

endpackage
`default_nettype wire

// ===== design/ray_triangle_intersect_core.sv =====
// Ray/triangle intersection core, Moller-Trumbore in exact fixed point.
// Depends on rti_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One ray, set through the configuration port, is tested against a stream of
// triangles, one triangle per transfer on the s_ side and one result per
// triangle on the m_ side, in order. The pipeline takes a triangle every clock
// and has 41 register stages (10 stages of arithmetic plus one stage per
// distance bit in the restoring divider). A stall on the m_ side holds the
// whole pipeline; s_tready follows m_tready or an empty output register.
// Configuration is to be written by the user only while no triangle is in
// flight; the core itself does not enforce this.
module ray_triangle_intersect_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // corner_a_x, corner_a_y, corner_a_z, corner_b_x .. corner_c_z, 32 bit each
    input  wire logic [rti_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // hit_distance(31), hit_point_x, hit_point_y, hit_point_z, zero pad
    output logic [rti_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // hit(1), miss_reason(3)
    output logic [rti_pkg::USER_W-1:0]           m_tuser,
    input  wire logic                            cfg_we,
    input  wire logic [rti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rti_pkg::REG_W-1:0]       cfg_data
);
    import rti_pkg::*;

    // Configuration
    logic signed [CW-1:0]    origin_reg [3];
    logic signed [CW-1:0]    dir_reg [3];
    logic [REG_W-1:0]        thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                origin_reg[i] <= '0;
                dir_reg[i]    <= '0;
            end
            thr_reg <= REG_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_X:  origin_reg[0] <= cfg_data[CW-1:0];
                REG_ORIGIN_Y:  origin_reg[1] <= cfg_data[CW-1:0];
                REG_ORIGIN_Z:  origin_reg[2] <= cfg_data[CW-1:0];
                REG_DIR_X:     dir_reg[0]    <= cfg_data[CW-1:0];
                REG_DIR_Y:     dir_reg[1]    <= cfg_data[CW-1:0];
                REG_DIR_Z:     dir_reg[2]    <= cfg_data[CW-1:0];
                REG_THRESHOLD: thr_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Direction widened to edge width, and its magnitude
    logic signed [EW-1:0] dext [3];
    logic [CW-1:0]        dmag [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dext[i] = {dir_reg[i][CW-1], dir_reg[i]};
            dmag[i] = dir_reg[i][CW-1] ? CW'(-dir_reg[i]) : CW'(dir_reg[i]);
        end
    end

    // Flow control: whole pipeline moves together
    logic [NST-1:0] vld_reg;
    logic           adv;
    assign adv      = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // Stage 1: edges and origin offset
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] sv_reg [3];
    logic signed [CW-1:0] ca [3];
    logic signed [CW-1:0] cb [3];
    logic signed [CW-1:0] cc [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ca[i] = s_tdata[i * FIELD_W +: CW];
            cb[i] = s_tdata[(i + 3) * FIELD_W +: CW];
            cc[i] = s_tdata[(i + 6) * FIELD_W +: CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= EW'(cb[i]) - EW'(ca[i]);
                e2_reg[i] <= EW'(cc[i]) - EW'(ca[i]);
                sv_reg[i] <= EW'(origin_reg[i]) - EW'(ca[i]);
            end
        end
    end

    // Stage 2: cross-product terms, h = dir x e2, q = s x e1
    logic signed [PW-1:0] hp_reg [6];
    logic signed [PW-1:0] qp_reg [6];
    logic signed [EW-1:0] e1b_reg [3];
    logic signed [EW-1:0] e2b_reg [3];
    logic signed [EW-1:0] svb_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            hp_reg[0] <= dext[1] * e2_reg[2];
            hp_reg[1] <= dext[2] * e2_reg[1];
            hp_reg[2] <= dext[2] * e2_reg[0];
            hp_reg[3] <= dext[0] * e2_reg[2];
            hp_reg[4] <= dext[0] * e2_reg[1];
            hp_reg[5] <= dext[1] * e2_reg[0];
            qp_reg[0] <= sv_reg[1] * e1_reg[2];
            qp_reg[1] <= sv_reg[2] * e1_reg[1];
            qp_reg[2] <= sv_reg[2] * e1_reg[0];
            qp_reg[3] <= sv_reg[0] * e1_reg[2];
            qp_reg[4] <= sv_reg[0] * e1_reg[1];
            qp_reg[5] <= sv_reg[1] * e1_reg[0];
            e1b_reg   <= e1_reg;
            e2b_reg   <= e2_reg;
            svb_reg   <= sv_reg;
        end
    end

    // Stage 3: cross-product components
    logic signed [XW-1:0] h_reg [3];
    logic signed [XW-1:0] q_reg [3];
    logic signed [EW-1:0] e1c_reg [3];
    logic signed [EW-1:0] e2c_reg [3];
    logic signed [EW-1:0] svc_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                h_reg[i] <= XW'(hp_reg[2 * i]) - XW'(hp_reg[2 * i + 1]);
                q_reg[i] <= XW'(qp_reg[2 * i]) - XW'(qp_reg[2 * i + 1]);
            end
            e1c_reg <= e1b_reg;
            e2c_reg <= e2b_reg;
            svc_reg <= svb_reg;
        end
    end

    // Stage 4: dot-product partial products, cross components cut in two slices
    // dot order: det = e1.h, un = s.h, vn = dir.q, tn = e2.q
    logic signed [HW-1:0] h_hi [3];
    logic signed [HW-1:0] q_hi [3];
    logic signed [EW:0]   h_lo [3];
    logic signed [EW:0]   q_lo [3];
    logic signed [XW-1:0] phi_reg [4][3];
    logic signed [XW-1:0] plo_reg [4][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            h_hi[i] = h_reg[i][XW-1:EW];
            q_hi[i] = q_reg[i][XW-1:EW];
            h_lo[i] = {1'b0, h_reg[i][EW-1:0]};
            q_lo[i] = {1'b0, q_reg[i][EW-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                phi_reg[0][i] <= e1c_reg[i] * h_hi[i];
                plo_reg[0][i] <= e1c_reg[i] * h_lo[i];
                phi_reg[1][i] <= svc_reg[i] * h_hi[i];
                plo_reg[1][i] <= svc_reg[i] * h_lo[i];
                phi_reg[2][i] <= dext[i] * q_hi[i];
                plo_reg[2][i] <= dext[i] * q_lo[i];
                phi_reg[3][i] <= e2c_reg[i] * q_hi[i];
                plo_reg[3][i] <= e2c_reg[i] * q_lo[i];
            end
        end
    end

    // Stage 5: rejoin slices
    logic signed [DW-1:0] tm_reg [4][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                for (int i = 0; i < 3; i++) begin
                    tm_reg[k][i] <= (DW'(phi_reg[k][i]) <<< EW) + DW'(plo_reg[k][i]);
                end
            end
        end
    end

    // Stage 6: dot sums
    logic signed [DW-1:0] dt_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                dt_reg[k] <= tm_reg[k][0] + tm_reg[k][1] + tm_reg[k][2];
            end
        end
    end

    // Stage 7: fold the determinant sign into the numerators
    logic signed [DW-1:0] adet_reg;
    logic signed [DW-1:0] un_reg;
    logic signed [DW-1:0] vn_reg;
    logic signed [DW-1:0] tn_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (dt_reg[0][DW-1]) begin
                adet_reg <= -dt_reg[0];
                un_reg   <= -dt_reg[1];
                vn_reg   <= -dt_reg[2];
                tn_reg   <= -dt_reg[3];
            end else begin
                adet_reg <= dt_reg[0];
                un_reg   <= dt_reg[1];
                vn_reg   <= dt_reg[2];
                tn_reg   <= dt_reg[3];
            end
        end
    end

    // Stage 8: exact inside tests
    logic signed [DW:0] uv_sum;
    logic signed [DW:0] adet_ext;
    miss_t              rs;
    assign uv_sum   = (DW+1)'(un_reg) + (DW+1)'(vn_reg);
    assign adet_ext = (DW+1)'(adet_reg);

    always_comb begin
        if (adet_reg == '0 || $unsigned(adet_reg) < DW'(thr_reg)) begin
            rs = MISS_PARALLEL;
        end else if (un_reg < 0 || adet_reg < un_reg) begin
            rs = MISS_U;
        end else if (vn_reg < 0 || adet_ext < uv_sum) begin
            rs = MISS_V;
        end else if (tn_reg <= 0) begin
            rs = MISS_BEHIND;
        end else begin
            rs = MISS_NONE;
        end
    end

    // Divider pipeline, one distance bit per stage, MSB first.
    // Index 0 is loaded by the test stage.
    logic [RW-1:0]   dv_rem_reg [QW];
    logic [QW-1:0]   dv_q_reg [QW+1];
    logic [DW-1:0]   dv_den_reg [QW];
    miss_t           dv_rs_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0] <= {tn_reg, {FRAC{1'b0}}};
            dv_q_reg[0]   <= '0;
            dv_den_reg[0] <= adet_reg;
            dv_rs_reg[0]  <= rs;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int B = QW - 1 - j;
        logic [CMPW-1:0] den_sh;
        logic [CMPW-1:0] rem_ext;
        logic            take;
        assign den_sh  = CMPW'(dv_den_reg[j]) << B;
        assign rem_ext = CMPW'(dv_rem_reg[j]);
        assign take    = rem_ext >= den_sh;

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_q_reg[j+1]   <= dv_q_reg[j] | (QW'(take) << B);
                dv_rs_reg[j+1]  <= dv_rs_reg[j];
            end
        end

        // Remainder and divisor are not needed past the last bit
        if (j < QW - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_rem_reg[j+1] <= take ? RW'(rem_ext - den_sh) : dv_rem_reg[j];
                    dv_den_reg[j+1] <= dv_den_reg[j];
                end
            end
        end
    end

    // Point products: distance times direction magnitude
    logic [MW-1:0] pm_reg [3];
    logic [QW-1:0] pd_reg;
    miss_t         prs_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                pm_reg[i] <= MW'(dv_q_reg[QW]) * MW'(dmag[i]);
            end
            pd_reg  <= dv_q_reg[QW];
            prs_reg <= dv_rs_reg[QW];
        end
    end

    // Output stage: offset, add origin, saturate; zero on a miss
    localparam logic signed [SW-1:0] PMAX = SW'((64'sd1 <<< (CW - 1)) - 1);
    localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);

    logic signed [SW-1:0]      off [3];
    logic signed [SW-1:0]      psum [3];
    logic signed [CW-1:0]      psat [3];
    logic                      hit_reg;
    miss_t                     ors_reg;
    logic [QW-1:0]             odist_reg;
    logic signed [FIELD_W-1:0] opt_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            off[i]  = SW'(pm_reg[i] >> FRAC);
            if (dir_reg[i][CW-1]) begin
                off[i] = -off[i];
            end
            psum[i] = SW'(origin_reg[i]) + off[i];
            if (psum[i] > PMAX) begin
                psat[i] = CW'(PMAX);
            end else if (psum[i] < PMIN) begin
                psat[i] = CW'(PMIN);
            end else begin
                psat[i] = CW'(psum[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg <= (prs_reg == MISS_NONE);
            ors_reg <= prs_reg;
            if (prs_reg == MISS_NONE) begin
                odist_reg <= pd_reg;
                for (int i = 0; i < 3; i++) begin
                    opt_reg[i] <= FIELD_W'(psat[i]);
                end
            end else begin
                odist_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    opt_reg[i] <= '0;
                end
            end
        end
    end

    assign m_tuser = {ors_reg, hit_reg};
    assign m_tdata = OUT_TDATA_W'({opt_reg[2], opt_reg[1], opt_reg[0], odist_reg});

endmodule
`default_nettype wire

// ===== tb/rti_checker.sv =====
// Scoreboard for the ray/triangle intersection core: watches both streams and
// the configuration port, predicts every result and compares. Uses rti_pkg.
`timescale 1ns / 1ps
module rti_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rti_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rti_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [rti_pkg::USER_W-1:0]      m_tuser,
    input  logic                            cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rti_pkg::REG_W-1:0]       cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import rti_pkg::*;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic        hit;
        miss_t       reason;
        logic [30:0] distance;
        logic [31:0] pt [3];
    } strike_t;

    logic [31:0] ray_reg [7];
    strike_t     strike_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void cross3(input wide_t p [3], input wide_t r [3],
                                   output wide_t o [3]);
        o[0] = p[1] * r[2] - p[2] * r[1];
        o[1] = p[2] * r[0] - p[0] * r[2];
        o[2] = p[0] * r[1] - p[1] * r[0];
    endfunction

    function automatic wide_t dot3(input wide_t p [3], input wide_t r [3]);
        return p[0] * r[0] + p[1] * r[1] + p[2] * r[2];
    endfunction

    // Exact Moller-Trumbore on wide signed integers
    function automatic strike_t predict_strike(input logic [IN_TDATA_W-1:0] d);
        strike_t res;
        logic signed [31:0] ca, cb, cc, ov, dv32;
        wide_t dw [3], e1 [3], e2 [3], sv [3], h [3], q [3];
        wide_t det, un, vn, tn, adet, num;
        longint qdist, mag, prod, off, p;
        longint maxc, minc;
        miss_t why;
        maxc = 64'sd2147483647;
        minc = -maxc - 1;
        for (int i = 0; i < 3; i++) begin
            ca = d[32*i +: 32];
            cb = d[32*(3+i) +: 32];
            cc = d[32*(6+i) +: 32];
            ov = ray_reg[i];
            dv32 = ray_reg[3+i];
            dw[i] = wide_t'(dv32);
            e1[i] = wide_t'(cb) - wide_t'(ca);
            e2[i] = wide_t'(cc) - wide_t'(ca);
            sv[i] = wide_t'(ov) - wide_t'(ca);
        end
        cross3(dw, e2, h);
        det = dot3(e1, h);
        un  = dot3(sv, h);
        cross3(sv, e1, q);
        vn  = dot3(dw, q);
        tn  = dot3(e2, q);
        adet = det;
        if (det < 0) begin
            adet = -det;
            un = -un;
            vn = -vn;
            tn = -tn;
        end
        why = MISS_NONE;
        if (det == 0 || adet < $signed({160'b0, ray_reg[REG_THRESHOLD]}))
            why = MISS_PARALLEL;
        else if (un < 0 || adet < un)
            why = MISS_U;
        else if (vn < 0 || adet < un + vn)
            why = MISS_V;
        else if (tn <= 0)
            why = MISS_BEHIND;

        res.hit = 1'b0;
        res.reason = why;
        res.distance = '0;
        for (int i = 0; i < 3; i++) res.pt[i] = '0;
        if (why != MISS_NONE) return res;

        // distance truncated towards zero, saturated
        num = tn * 65536;
        if (num >= wide_t'(maxc) * adet) qdist = maxc;
        else begin
            num   = num / adet;
            qdist = longint'(num);
        end
        res.hit = 1'b1;
        res.distance = qdist[30:0];
        for (int i = 0; i < 3; i++) begin
            dv32 = ray_reg[3+i];
            ov   = ray_reg[i];
            mag  = (dv32 < 0) ? -longint'(dv32) : longint'(dv32);
            prod = (qdist * mag) >>> 16;
            off  = (dv32 < 0) ? -prod : prod;
            p    = longint'(ov) + off;
            if (p > maxc) p = maxc;
            if (p < minc) p = minc;
            res.pt[i] = p[31:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        strike_t want;
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) ray_reg[i] <= '0;
            ray_reg[REG_THRESHOLD] <= 32'd1;
            strike_q.delete();
        end else begin
            if (cfg_we && cfg_index < 3'd7) ray_reg[cfg_index] <= cfg_data;
            if (s_tvalid && s_tready) strike_q.push_back(predict_strike(s_tdata));
            if (m_tvalid && m_tready) begin
                if (strike_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[30:0], 0);
                end else begin
                    want = strike_q.pop_front();
                    if (m_tuser[0] !== want.hit)
                        report_mismatch("hit", m_tuser[0], want.hit);
                    if (m_tuser[3:1] !== want.reason)
                        report_mismatch("miss_reason", m_tuser[3:1], want.reason);
                    if (m_tdata[30:0] !== want.distance)
                        report_mismatch("hit_distance", m_tdata[30:0], want.distance);
                    for (int i = 0; i < 3; i++)
                        if (m_tdata[31+32*i +: 32] !== want.pt[i])
                            report_mismatch($sformatf("hit_point[%0d]", i),
                                            m_tdata[31+32*i +: 32], want.pt[i]);
                end
            end
        end
        pending <= strike_q.size();
    end
endmodule

// ===== tb/tb_ray_triangle_intersect_core.sv =====
// Top of the ray/triangle intersection testbench: clock, reset, ray settings,
// triangle stimulus and verdict. Uses rti_pkg, rti_checker and the core.
`timescale 1ns / 1ps
module tb_ray_triangle_intersect_core;
    import rti_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint ONE = 64'sd65536;
    localparam int NCFG = 9;
    localparam int RAND_PER_CFG = 160;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [USER_W-1:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_data = '0;
    int fail_count, pending;

    int send_idle = 21;
    int recv_idle = 79;
    bit hold_req = 1'b0;
    longint ray_o [3];
    longint ray_d [3];

    always #4 aclk = ~aclk;

    ray_triangle_intersect_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rti_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Result side: random back-pressure, or a long hold when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Watchdog
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_corners(input longint c [9]);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[32*i +: 32] = c[i][31:0];
        return d;
    endfunction

    function automatic longint spread_rand(input longint s);
        return longint'({$urandom, $urandom} % (2 * s + 1)) - s;
    endfunction

    // Offer one triangle and wait for its transfer
    task automatic send_triangle(input longint c [9]);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_corners(c);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Triangle with the ray point as centroid, or other random shapes
    task automatic send_random;
        longint c [9];
        longint pt, ts, s, e1, e2;
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            ts = longint'($urandom_range(0, 3 * 65536)) - 65536;
            s  = 64'sd1 <<< $urandom_range(2, 26);
            for (int i = 0; i < 3; i++) begin
                pt = ray_o[i] + ((ray_d[i] * ts) >>> 16);
                e1 = spread_rand(s);
                e2 = spread_rand(s);
                c[i]   = pt + e1;
                c[3+i] = pt + e2;
                c[6+i] = pt - e1 - e2;
            end
        end else if (pick < 85) begin
            for (int i = 0; i < 9; i++) c[i] = longint'($urandom);
        end else begin
            for (int i = 0; i < 9; i++) c[i] = spread_rand(64'sd1 <<< 20);
        end
        send_triangle(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[31:0];
        @(posedge aclk);
    endtask

    task automatic set_ray(input longint o [3], input longint d [3],
                           input longint thr);
        for (int i = 0; i < 3; i++) begin
            write_reg(CFG_IDX_W'(REG_ORIGIN_X + i), o[i]);
            write_reg(CFG_IDX_W'(REG_DIR_X + i), d[i]);
            ray_o[i] = longint'(signed'(o[i][31:0]));
            ray_d[i] = longint'(signed'(d[i][31:0]));
        end
        write_reg(REG_THRESHOLD, thr);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic tri9(input longint ax, ay, az, bx, by, bz, cx, cy, cz);
        longint c [9];
        c = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        send_triangle(c);
    endtask

    // Directed triangles for the current ray setting
    task automatic send_directed(input int k);
        longint z, mx, mn;
        z  = 2 * ONE;
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;
        case (k)
            0: begin
                tri9(0, 0, z, ONE, 0, z, 0, ONE, z);
                tri9(mx, mx, mx, mx, mx, mx, mx, mx, mx);
            end
            1: begin
                tri9(0, 0, z, ONE, 0, z, 0, ONE, z);              // vertex a on ray
                tri9(0, 0, z, 0, ONE, z, ONE, 0, z);              // reversed winding
                tri9(-ONE, 0, z, 0, 0, z, -ONE, ONE, z);          // u at one
                tri9(ONE, ONE, z, -ONE, 2 * ONE, z, 0, 0, z);     // v at one
                tri9(ONE, ONE, z, -ONE, 0, z, ONE, 0, z);         // on edge bc
                tri9(-ONE, 0, z, ONE, 0, z, 0, ONE, z);           // on edge ab
                tri9(0, 0, -z, ONE, 0, -z, 0, ONE, -z);           // behind origin
                tri9(0, 0, 0, ONE, 0, 0, 0, ONE, 0);              // zero distance
                tri9(0, 0, 0, 0, 0, ONE, ONE, 0, 0);              // parallel
                tri9(ONE, ONE, z, 2 * ONE, ONE, z, ONE, 2 * ONE, z);
                tri9(-ONE, ONE, z, ONE, ONE, z, 0, 2 * ONE, z);   // v outside
                tri9(mx, mx, mx, mx, mx, mx, mx, mx, mx);
                tri9(mn, mn, mn, mn, mn, mn, mn, mn, mn);
                tri9(mx, mn, mx, mn, mx, mn, mx, mn, mx);
                tri9(mn, mn, mx, mx, mn, mx, mn, mx, mx);
                tri9(0, 0, 0, 0, 0, 0, 0, 0, 0);
            end
            2: tri9(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1);      // distance below one lsb
            3: begin                                              // saturated distance
                tri9(-ONE, -ONE, mx, ONE, -ONE, mx, 0, ONE, mx);
                tri9(mn, mn, mx, mx, mn, mx, 0, mx, mx);
            end
            default: ;
        endcase
    endtask

    task automatic pick_ray(input int k);
        longint o [3], d [3], thr;
        o = '{0, 0, 0};
        thr = 1;
        case (k)
            1: d = '{0, 0, ONE};
            2: begin d = '{0, 0, 64'sd2147483647}; thr = 0; end
            3: d = '{0, 0, 1};
            4: begin
                o = '{ONE, -ONE, 3 * ONE};
                d = '{ONE / 2, ONE / 3, -ONE};
                thr = 64'hFFFF_FFFF;
            end
            5: begin
                o = '{-64'sd2147483648, 64'sd2147483647, -64'sd2147483648};
                d = '{64'sd2147483647, -64'sd2147483648, 64'sd2147483647};
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    o[i] = ($urandom_range(1)) ? longint'($urandom)
                                               : spread_rand(64'sd1 <<< 22);
                    d[i] = ($urandom_range(1)) ? longint'($urandom)
                                               : spread_rand(64'sd1 <<< 18);
                end
                thr = ($urandom_range(3) == 0) ? longint'($urandom)
                                               : longint'($urandom_range(0, 16));
            end
        endcase
        set_ray(o, d, thr);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // write to an index with no register behind it
        write_reg(REG_UNUSED, longint'($urandom));
        cfg_we <= 1'b0;
        @(posedge aclk);
        ray_o = '{0, 0, 0};
        ray_d = '{0, 0, 0};
        for (int k = 0; k < NCFG; k++) begin
            case (k / 3)
                0: begin send_idle = 21; recv_idle = 79; end
                1: begin send_idle = 79; recv_idle = 21; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            if (k > 0) pick_ray(k);
            if (k == 6) hold_req = 1'b1;
            send_directed(k);
            for (int n = 0; n < RAND_PER_CFG; n++) send_random();
            s_tvalid <= 1'b0;
            // let the checker count the last transfer, then drain before
            // touching the ray
            @(posedge aclk);
            while (pending != 0 || m_tvalid) @(posedge aclk);
            repeat (50) @(posedge aclk);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/rti_pkg.sv
design/ray_triangle_intersect_core.sv
tb/rti_checker.sv
tb/tb_ray_triangle_intersect_core.sv
